/* hw/rtl/nrsp_pkg.sv */
// Shared definitions for the nearest ray-sphere pick block.
// Holds table sizing, request and register codes, and the square root unit's port structs.
// No dependencies.
`default_nettype none

package nrsp_pkg;

  // Table sizing
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Request codes carried on op
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes (word address bit 2)
  localparam logic REG_NUM_ENTRIES   = 1'b0;
  localparam logic REG_SPHERE_RADIUS = 1'b1;

  // Reset values of the registers
  localparam logic [6:0]  NUM_ENTRIES_RST   = 7'd27;
  localparam logic [14:0] SPHERE_RADIUS_RST = 15'd256;

  // Square root unit start and result
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_resp_t;

endpackage

`default_nettype wire

/* hw/rtl/nearest_ray_sphere_pick.sv */
// Nearest ray-sphere pick: top level with center table, sequencer and datapath.
// Depends on nrsp_pkg and nrsp_isqrt.
//
// Load requests (op = 0) write one sphere center into a 64-entry table and
// produce no result. A query request (op = 1) walks entries 0 to
// num_entries-1 (at most 64) and returns one result: hit flag, index of the
// nearest sphere hit in front of the origin (lowest index on a tie) and its
// Q8.8 distance, saturated at 65535. Every entry scanned must have been loaded
// since reset. Each entry costs one table read and a run of products on a single
// shared 33x33 multiplier; unless it misses on the discriminant, it then takes a
// square root, and unless the nearer root lies behind the origin or saturates,
// a divide and a second square root. The square root unit and the divider are
// bit-serial. While a query runs, in_stall is high; loads and queries are taken
// again as soon as the result sits in the output register, even if out_stall
// holds it there.
`default_nettype none

module nearest_ray_sphere_pick (
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic [5:0]         entry_index,
  input  wire logic signed [15:0] center_x,
  input  wire logic signed [15:0] center_y,
  input  wire logic signed [15:0] center_z,
  input  wire logic signed [15:0] ray_origin_x,
  input  wire logic signed [15:0] ray_origin_y,
  input  wire logic signed [15:0] ray_origin_z,
  input  wire logic signed [15:0] ray_dir_x,
  input  wire logic signed [15:0] ray_dir_y,
  input  wire logic signed [15:0] ray_dir_z,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic [5:0]              hit_index,
  output logic [15:0]             hit_distance,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import nrsp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_READ  = 10'b00_0000_0010,
    S_MUL   = 10'b00_0000_0100,
    S_SQRT1 = 10'b00_0000_1000,
    S_NUM   = 10'b00_0001_0000,
    S_MULU  = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_SQRT2 = 10'b00_1000_0000,
    S_NEXT  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  localparam logic [4:0] STEP_CHECK = 5'd21;

  state_t state;

  // Registers
  logic [6:0]  num_entries;
  logic [14:0] sphere_radius;

  // Center table
  logic [47:0] mem [MAX_ENTRIES];
  logic [47:0] rd_data;

  // Query context
  logic signed [15:0] o_x, o_y, o_z, d_x, d_y, d_z;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   n_clip;
  logic [4:0]         step;

  // Per-entry datapath
  logic signed [16:0] oc_x, oc_y, oc_z;
  logic signed [32:0] ma, mb;
  logic signed [65:0] p;
  logic [31:0]        a;
  logic signed [33:0] bh;
  logic signed [32:0] t;
  logic [65:0]        x;
  logic signed [34:0] num;
  logic [31:0]        drem;
  logic [31:0]        dlo;
  logic [4:0]         dcnt;
  logic [32:0]        rem2;
  logic               dge;
  logic [31:0]        dlo_next;
  logic               disc_miss;
  logic [63:0]        h_op;

  // Candidate and best so far
  logic               cand_hit;
  logic [15:0]        cand_dist;
  logic               found;
  logic [15:0]        best;
  logic [IDX_W-1:0]   best_idx;
  logic               better;

  sqrt_req_t  sq_req;
  sqrt_resp_t sq_resp;

  logic in_acc;
  logic cfg_wr;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries   <= NUM_ENTRIES_RST;
      sphere_radius <= SPHERE_RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NUM_ENTRIES:   num_entries   <= pwdata[6:0];
        REG_SPHERE_RADIUS: sphere_radius <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_NUM_ENTRIES:   prdata = {25'd0, num_entries};
      REG_SPHERE_RADIUS: prdata = {17'd0, sphere_radius};
      default:           prdata = '0;
    endcase
  end

  // Center table: write on load, registered read of the current entry
  always_ff @(posedge clk) begin
    if (in_acc && op == OP_LOAD && {1'b0, entry_index} < 7'(MAX_ENTRIES)) begin
      mem[entry_index] <= {center_x, center_y, center_z};
    end
    rd_data <= mem[idx];
  end

  assign n_clip = (num_entries > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : num_entries;

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_NUM) begin
      ma = {1'b0, num[31:0]};
      mb = {1'b0, num[31:0]};
    end else begin
      case (step)
        5'd1:  begin ma = 33'(d_x); mb = 33'(d_x);  end
        5'd2:  begin ma = 33'(d_y); mb = 33'(d_y);  end
        5'd3:  begin ma = 33'(d_z); mb = 33'(d_z);  end
        5'd4:  begin ma = 33'(d_x); mb = 33'(oc_x); end
        5'd5:  begin ma = 33'(d_y); mb = 33'(oc_y); end
        5'd6:  begin ma = 33'(d_z); mb = 33'(oc_z); end
        5'd7:  begin ma = 33'(d_y); mb = 33'(oc_z); end
        5'd8:  begin ma = 33'(d_z); mb = 33'(oc_y); end
        5'd10: begin ma = t;        mb = t;         end
        5'd11: begin ma = 33'(d_z); mb = 33'(oc_x); end
        5'd12: begin ma = 33'(d_x); mb = 33'(oc_z); end
        5'd14: begin ma = t;        mb = t;         end
        5'd15: begin ma = 33'(d_x); mb = 33'(oc_y); end
        5'd16: begin ma = 33'(d_y); mb = 33'(oc_x); end
        5'd18: begin ma = t;        mb = t;         end
        5'd19: begin
          ma = {18'd0, sphere_radius};
          mb = {18'd0, sphere_radius};
        end
        5'd20: begin ma = {1'b0, a}; mb = {3'd0, p[29:0]}; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  // Discriminant test and quarter discriminant (x <= a*r*r < 2^62 when taken)
  assign disc_miss = (a == 32'd0) || (x > $unsigned(p));
  assign h_op      = {2'b00, p[61:0] - x[61:0]};

  // Restoring divide step
  assign rem2     = {drem, dlo[31]};
  assign dge      = (rem2 >= {1'b0, a});
  assign dlo_next = {dlo[30:0], dge};

  // Square root unit requests
  always_comb begin
    sq_req.start   = 1'b0;
    sq_req.operand = h_op;
    if (state == S_MUL && step == STEP_CHECK && !disc_miss) begin
      sq_req.start = 1'b1;
    end else if (state == S_DIV && dcnt == 5'd31) begin
      sq_req.start   = 1'b1;
      sq_req.operand = {32'd0, dlo_next};
    end
  end

  nrsp_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .resp (sq_resp)
  );

  assign better = cand_hit && (!found || cand_dist < best);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      found     <= 1'b0;
      step      <= '0;
      dcnt      <= '0;
      idx       <= '0;
    end else begin
      // drop a result once taken, unless a new one replaces it now
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && op == OP_QUERY) begin
            found <= 1'b0;
            idx   <= '0;
            if (n_clip == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 5'd1;
          if (step == STEP_CHECK) begin
            if (disc_miss) begin
              cand_hit <= 1'b0;
              state    <= S_NEXT;
            end else begin
              state <= S_SQRT1;
            end
          end
        end
        S_SQRT1: begin
          if (sq_resp.done) begin
            state <= S_NUM;
          end
        end
        S_NUM: begin
          if (num <= 35'sd0) begin
            cand_hit <= 1'b0;
            state    <= S_NEXT;
          end else if (num[34:32] != 3'd0) begin
            cand_hit  <= 1'b1;
            cand_dist <= 16'hFFFF;
            state     <= S_NEXT;
          end else begin
            state <= S_MULU;
          end
        end
        S_MULU: begin
          if (p[63:32] >= a) begin
            cand_hit  <= 1'b1;
            cand_dist <= 16'hFFFF;
            state     <= S_NEXT;
          end else begin
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            state <= S_SQRT2;
          end
        end
        S_SQRT2: begin
          if (sq_resp.done) begin
            cand_hit  <= (sq_resp.root[15:0] != 16'd0);
            cand_dist <= sq_resp.root[15:0];
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (better) begin
            found    <= 1'b1;
          end
          if (CNT_W'(idx) + CNT_W'(1) == n_eff) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // latch the ray
    if (state == S_IDLE && in_acc && op == OP_QUERY) begin
      o_x   <= ray_origin_x;
      o_y   <= ray_origin_y;
      o_z   <= ray_origin_z;
      d_x   <= ray_dir_x;
      d_y   <= ray_dir_y;
      d_z   <= ray_dir_z;
      n_eff <= n_clip;
    end
    // accumulate products as they come out of the multiplier
    if (state == S_MUL) begin
      case (step)
        5'd0: begin
          oc_x <= 17'(o_x) - 17'($signed(rd_data[47:32]));
          oc_y <= 17'(o_y) - 17'($signed(rd_data[31:16]));
          oc_z <= 17'(o_z) - 17'($signed(rd_data[15:0]));
        end
        5'd2:                a  <= p[31:0];
        5'd3, 5'd4:          a  <= a + p[31:0];
        5'd5:                bh <= $signed(p[33:0]);
        5'd6, 5'd7:          bh <= bh + $signed(p[33:0]);
        5'd8, 5'd12, 5'd16:  t  <= $signed(p[32:0]);
        5'd9, 5'd13, 5'd17:  t  <= t - $signed(p[32:0]);
        5'd11:               x  <= $unsigned(p);
        5'd15, 5'd19:        x  <= x + $unsigned(p);
        default: ;
      endcase
    end
    // nearer root numerator
    if (state == S_SQRT1 && sq_resp.done) begin
      num <= -35'(bh) - $signed({3'b000, sq_resp.root});
    end
    // load and run the divider
    if (state == S_MULU) begin
      drem <= p[63:32];
      dlo  <= p[31:0];
    end
    if (state == S_DIV) begin
      drem <= dge ? 32'(rem2 - {1'b0, a}) : rem2[31:0];
      dlo  <= dlo_next;
    end
    // keep the best candidate
    if (state == S_NEXT && better) begin
      best     <= cand_dist;
      best_idx <= idx;
    end
    // hand the result to the output register
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      hit          <= found;
      hit_index    <= found ? 6'(best_idx) : 6'd0;
      hit_distance <= found ? best : 16'd0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nrsp_isqrt.sv */
// Bit-serial integer square root, floor(sqrt(v)) of a 64-bit value.
// One result bit per cycle, 32 result bits per operand; depends on nrsp_pkg.
`default_nettype none

module nrsp_isqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nrsp_pkg::sqrt_req_t  req,
  output nrsp_pkg::sqrt_resp_t    resp
);
  import nrsp_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [63:0] val;
  logic [33:0] rem;
  logic [31:0] root;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [33:0] rem_next;
  logic [31:0] root_next;

  // One restoring step: bring down two bits, try root*4+1
  always_comb begin
    rem_sh    = {rem, val[63:62]};
    trial     = {2'b00, root, 2'b01};
    ge        = (rem_sh >= trial);
    rem_next  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
    root_next = {root[30:0], ge};
  end

  // Control: start loads the operand, done pulses after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      val  <= req.operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[61:0], 2'b00};
      rem  <= rem_next;
      root <= root_next;
    end
  end

  assign resp.done = done;
  assign resp.root = root;

endmodule

`default_nettype wire

/* hw/rtl/nrsp_checker.sv */
// Port-level checks for the nearest ray-sphere pick block, bound to its top level.
// Depends on nrsp_pkg and the top level's ports.
`default_nettype none

module nrsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        op,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        hit,
  input wire logic [5:0]  hit_index,
  input wire logic [15:0] hit_distance
);
  import nrsp_pkg::*;

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_index)
      && $stable(hit_distance))
    else $error("result changed while stalled");

  // A miss reports zero index and distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_index == 6'd0 && hit_distance == 16'd0)
    else $error("miss with nonzero index or distance");

  // A hit is always in front of the origin
  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_distance != 16'd0)
    else $error("hit at zero distance");

  // A query always occupies the block for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_QUERY |=> in_stall)
    else $error("request taken right after a query");

endmodule

bind nearest_ray_sphere_pick nrsp_checker u_nrsp_checker (.*);

`default_nettype wire

/* verif/tb_nearest_ray_sphere_pick.sv */
// Self-checking testbench for nearest_ray_sphere_pick: loads centers, fires rays and
// checks each pick against an integer predictor kept inside a small scoreboard class.
// Depends on nrsp_pkg and the nearest_ray_sphere_pick RTL.
`timescale 1ns / 100ps

module tb_nearest_ray_sphere_pick;
  import nrsp_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_LOAD;
  logic [5:0] entry_index = '0;
  logic signed [15:0] center_x = '0, center_y = '0, center_z = '0;
  logic signed [15:0] ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
  logic signed [15:0] ray_dir_x = '0, ray_dir_y = '0, ray_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [5:0] hit_index;
  logic [15:0] hit_distance;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int unsigned mismatches = 0;
  longint unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit hold_out = 1'b0;
  bit loaded[MAX_ENTRIES];
  logic signed [15:0] shadow_c[MAX_ENTRIES][3];

  nearest_ray_sphere_pick u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  typedef struct {
    bit               hit;
    logic [5:0]       idx;
    logic [15:0]      rng;
  } pick_t;

  class pick_board;
    logic signed [15:0] cx[MAX_ENTRIES], cy[MAX_ENTRIES], cz[MAX_ENTRIES];
    logic [6:0]  n_entries = NUM_ENTRIES_RST;
    logic [14:0] radius = SPHERE_RADIUS_RST;
    pick_t picks[$];

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned sqm(longint v);
      longint unsigned m = (v < 0) ? longint'(-v) : v;
      return m * m;
    endfunction

    function longint unsigned sadd(longint unsigned x, longint unsigned y);
      longint unsigned s = x + y;
      return (s < x) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    // Q8.8 distance along the ray to sphere e, zero on a miss
    function longint unsigned sphere_range(longint o[3], longint d[3], int e);
      longint ox = o[0] - longint'(cx[e]);
      longint oy = o[1] - longint'(cy[e]);
      longint oz = o[2] - longint'(cz[e]);
      longint unsigned a = sqm(d[0]) + sqm(d[1]) + sqm(d[2]);
      longint bh = d[0] * ox + d[1] * oy + d[2] * oz;
      longint unsigned x, ar2, s, u, q, rr;
      longint num;
      if (a == 0) return 0;
      x = sqm(d[1] * oz - d[2] * oy);
      x = sadd(x, sqm(d[2] * ox - d[0] * oz));
      x = sadd(x, sqm(d[0] * oy - d[1] * ox));
      rr = radius;
      ar2 = a * (rr * rr);
      if (x > ar2) return 0;
      s = isqrt(ar2 - x);
      num = -bh - longint'(s);
      if (num <= 0) return 0;
      u = num;
      if (u >= (64'd1 << 32)) return 65535;
      q = (u * u) / a;
      if (q >= (64'd1 << 32)) return 65535;
      return isqrt(q);
    endfunction

    // Apply one accepted request to the table or queue its expected pick
    function void note_request(logic o_p, logic [5:0] ei, logic signed [15:0] c[3],
                               logic signed [15:0] ro[3], logic signed [15:0] rd[3]);
      longint o[3], d[3];
      longint unsigned best = 0, dv;
      int best_i = 0;
      int n;
      pick_t p;
      if (o_p == OP_LOAD) begin
        cx[ei] = c[0];
        cy[ei] = c[1];
        cz[ei] = c[2];
        return;
      end
      for (int k = 0; k < 3; k++) begin
        o[k] = ro[k];
        d[k] = rd[k];
      end
      n = (n_entries > MAX_ENTRIES) ? MAX_ENTRIES : n_entries;
      for (int e = 0; e < n; e++) begin
        dv = sphere_range(o, d, e);
        if (dv != 0 && (best == 0 || dv < best)) begin
          best = dv;
          best_i = e;
        end
      end
      p.hit = (best != 0);
      p.idx = p.hit ? best_i[5:0] : 6'd0;
      p.rng = p.hit ? best[15:0] : 16'd0;
      picks = {picks, p};
    endfunction

    task check_pick(logic h, logic [5:0] idx, logic [15:0] rng);
      pick_t p;
      if (picks.size() == 0) begin
        report("unexpected result, hit", h, 0);
        return;
      end
      p = picks.pop_front();
      if (h !== p.hit) report("hit", h, p.hit);
      if (idx !== p.idx) report("hit_index", idx, p.idx);
      if (rng !== p.rng) report("hit_distance", rng, p.rng);
    endtask
  endclass

  pick_board board = new();

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_pick(hit, hit_index, hit_distance);
  end

  // Drive the result stall: random, or a long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_out && hold_left == 0) begin
        hold_left = 600;
        hold_out = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_NUM_ENTRIES) board.n_entries = val[6:0];
    else board.radius = val[14:0];
  endtask

  // Offer one request and hold it until taken
  task automatic send_req(input logic o_p, input logic [5:0] ei, input logic signed [15:0] c[3],
                          input logic signed [15:0] ro[3], input logic signed [15:0] rd[3]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    op <= o_p;
    entry_index <= ei;
    center_x <= c[0]; center_y <= c[1]; center_z <= c[2];
    ray_origin_x <= ro[0]; ray_origin_y <= ro[1]; ray_origin_z <= ro[2];
    ray_dir_x <= rd[0]; ray_dir_y <= rd[1]; ray_dir_z <= rd[2];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(o_p, ei, c, ro, rd);
    if (o_p == OP_LOAD) begin
      loaded[ei] = 1'b1;
      shadow_c[ei] = c;
    end
  endtask

  task automatic load_center(input int e, input int x, input int y, input int z);
    logic signed [15:0] c[3], zz[3];
    c = '{x[15:0], y[15:0], z[15:0]};
    zz = '{default: 16'sd0};
    send_req(OP_LOAD, e[5:0], c, zz, zz);
  endtask

  task automatic cast_ray(input int ox, input int oy, input int oz,
                          input int dx, input int dy, input int dz);
    logic signed [15:0] ro[3], rd[3], zz[3];
    ro = '{ox[15:0], oy[15:0], oz[15:0]};
    rd = '{dx[15:0], dy[15:0], dz[15:0]};
    zz = '{default: 16'sd0};
    send_req(OP_QUERY, 6'd0, zz, ro, rd);
  endtask

  // Random request; a ray scanning an unloaded entry becomes a load of it
  task automatic random_req();
    int gap, e, sh, n;
    int o[3], d[3];
    gap = -1;
    n = (board.n_entries > MAX_ENTRIES) ? MAX_ENTRIES : board.n_entries;
    for (int k = n - 1; k >= 0; k--) if (!loaded[k]) gap = k;
    if (gap >= 0) begin
      load_center(gap, $urandom, $urandom, $urandom);
    end else if ($urandom_range(99) < 30) begin
      e = $urandom_range(63);
      if ($urandom_range(1)) load_center(e, $urandom, $urandom, $urandom);
      else load_center(e, $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                       $urandom_range(4095) - 2048);
    end else if ($urandom_range(99) < 65) begin
      // aim at a loaded center from a random origin
      e = $urandom_range(n - 1);
      sh = $urandom_range(6, 1);
      for (int k = 0; k < 3; k++) begin
        o[k] = $signed(16'($urandom));
        d[k] = (int'(shadow_c[e][k]) - o[k]) >>> sh;
        if ($urandom_range(3) == 0) d[k] = -d[k];
      end
      cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    end else begin
      cast_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Withdraw the request and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (board.picks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int n_cfg[6], r_cfg[6];
    n_cfg = '{1, 64, 3, 16, 5, 2};
    r_cfg = '{1, 32767, 512, 4096, 100, 256};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    reg_write(REG_NUM_ENTRIES, 32'd8);
    reg_write(REG_SPHERE_RADIUS, 32'd256);

    // Directed: extremes, ties, misses and saturation
    load_center(0, 32767, 32767, 32767);
    load_center(1, -32768, -32768, -32768);
    load_center(2, 1024, 0, 0);
    load_center(3, 1024, 0, 0);
    load_center(4, 0, 2048, 0);
    load_center(5, 0, 0, -2048);
    load_center(6, 32767, -32768, 0);
    load_center(7, -512, 256, 128);
    cast_ray(0, 0, 0, 256, 0, 0);              // tie on entries 2 and 3
    cast_ray(0, 0, 0, 0, 0, 0);                // zero direction
    cast_ray(0, 0, 0, -256, 0, 0);             // sphere behind the origin
    cast_ray(1024, 0, 0, 256, 0, 0);           // origin at a center
    cast_ray(0, 0, 0, 0, 256, 256);            // clean miss
    cast_ray(-32768, -32768, -32768, 1, 1, 1); // far diagonal, saturates
    cast_ray(32767, 32767, 32767, -32768, -32768, -32768);
    cast_ray(-32768, 32767, -32768, 32767, -32768, 32767);
    cast_ray(0, 0, 0, 0, -1, 0);
    cast_ray(0, 0, 0, 0, 0, -32768);
    drain();
    reg_write(REG_SPHERE_RADIUS, 32'd32767);
    cast_ray(0, 0, 0, 32767, 32767, 32767);
    cast_ray(-1, -1, -1, -32768, -32768, 1);

    // Random phases over several register settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      reg_write(REG_NUM_ENTRIES, n_cfg[ph]);
      reg_write(REG_SPHERE_RADIUS, r_cfg[ph]);
      send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 67 : 0;
      recv_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 13 : 0;
      if (ph == 2 || ph == 4) hold_out = 1'b1;
      for (int i = 0; i < 20; i++) random_req();
    end
    recv_idle_pct = 0;
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && board.picks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/nrsp_pkg.sv
hw/rtl/nrsp_isqrt.sv
hw/rtl/nearest_ray_sphere_pick.sv
hw/rtl/nrsp_checker.sv
verif/tb_nearest_ray_sphere_pick.sv
